[sv/rpn_pkg.sv]
// rpn_pkg: shared types, character codes, status codes and the microcode ROM
// for the reverse Polish evaluator. No dependencies.
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int VALUE_W         = 32;
  localparam int STATUS_W        = 3;
  localparam int CHAR_W          = 8;
  localparam int MUL_CHUNK       = 16;  // multiplier bits consumed per step

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BADCHAR   = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_t;

  // Datapath actions selected by the control word
  typedef enum logic [3:0] {
    A_NOP,
    A_END,
    A_ENDSKIP,
    A_FAIL,
    A_PUSH,
    A_POP,
    A_ADD,
    A_SUB,
    A_MULINIT,
    A_MULSTEP,
    A_MULFIN,
    A_DIVINIT,
    A_DIVSTEP,
    A_DIVFIN
  } act_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    act_t act;
    logic emit;    // produces a result transaction, waits for a free output slot
    logic loop;    // jump to target while the step count has not run out
    logic last;    // final step of the routine
    upc_t target;
  } uop_t;

  // Routine entry points
  localparam upc_t UA_NOP     = 4'd0;
  localparam upc_t UA_END     = 4'd1;
  localparam upc_t UA_ENDSKIP = 4'd2;
  localparam upc_t UA_FAIL    = 4'd3;
  localparam upc_t UA_PUSH    = 4'd4;
  localparam upc_t UA_POP     = 4'd5;
  localparam upc_t UA_ADD     = 4'd6;
  localparam upc_t UA_SUB     = 4'd7;
  localparam upc_t UA_MUL     = 4'd8;
  localparam upc_t UA_MULLOOP = 4'd9;
  localparam upc_t UA_MULFIN  = 4'd10;
  localparam upc_t UA_DIV     = 4'd11;
  localparam upc_t UA_DIVLOOP = 4'd12;
  localparam upc_t UA_DIVFIN  = 4'd13;

  function automatic uop_t urom(input upc_t addr);
    uop_t u;
    u = '{act: A_NOP, emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
    case (addr)
      UA_NOP:     u = '{act: A_NOP,     emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
      UA_END:     u = '{act: A_END,     emit: 1'b1, loop: 1'b0, last: 1'b1, target: UA_NOP};
      UA_ENDSKIP: u = '{act: A_ENDSKIP, emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
      UA_FAIL:    u = '{act: A_FAIL,    emit: 1'b1, loop: 1'b0, last: 1'b1, target: UA_NOP};
      UA_PUSH:    u = '{act: A_PUSH,    emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
      UA_POP:     u = '{act: A_POP,     emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
      UA_ADD:     u = '{act: A_ADD,     emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
      UA_SUB:     u = '{act: A_SUB,     emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
      UA_MUL:     u = '{act: A_MULINIT, emit: 1'b0, loop: 1'b0, last: 1'b0, target: UA_NOP};
      UA_MULLOOP: u = '{act: A_MULSTEP, emit: 1'b0, loop: 1'b1, last: 1'b0,
                        target: UA_MULLOOP};
      UA_MULFIN:  u = '{act: A_MULFIN,  emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
      UA_DIV:     u = '{act: A_DIVINIT, emit: 1'b0, loop: 1'b0, last: 1'b0, target: UA_NOP};
      UA_DIVLOOP: u = '{act: A_DIVSTEP, emit: 1'b0, loop: 1'b1, last: 1'b0,
                        target: UA_DIVLOOP};
      UA_DIVFIN:  u = '{act: A_DIVFIN,  emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
      default:    u = '{act: A_NOP,     emit: 1'b0, loop: 1'b0, last: 1'b1, target: UA_NOP};
    endcase
    return u;
  endfunction

endpackage

[sv/rpn_ram.sv]
// rpn_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rpn_stack_evaluator_top.sv]
// rpn_stack_evaluator_top: reverse Polish evaluator, one character per transaction.
// Each character is taken in an accept cycle and then runs its microroutine; no new character
//   is accepted until that routine ends. '*' and '/' loop in the chunked multiplier
//   and the one-bit-per-step restoring divider.
// Result leaves through an output register; an emitting step waits only while it is full and not being read.
// Reset (sync, active high): empty stack, running result zero, no skip; RAM not cleared.
module rpn_stack_evaluator_top import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  logic [CHAR_W-1:0]   char_in,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [VALUE_W-1:0]  value,
  output logic [STATUS_W-1:0] status
);

  localparam int DW        = DATA_WIDTH;
  localparam int AW        = $clog2(STACK_DEPTH);
  localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);
  localparam int MC        = (DATA_WIDTH < MUL_CHUNK) ? DATA_WIDTH : MUL_CHUNK;
  localparam int MUL_STEPS = (DATA_WIDTH + MC - 1) / MC;
  localparam int CW        = $clog2(DATA_WIDTH + 1);

  // Sequencer state
  logic               busy;
  upc_t               upc;
  uop_t               ctrl;
  logic               exec;
  logic               out_free;

  // Architectural state. The top of stack lives in tos; entries below it in RAM,
  // so an operator needs only one RAM read, prefetched during the accept cycle.
  logic [DEPTH_W-1:0] depth;
  logic [DW-1:0]      tos;
  logic [DW-1:0]      running;
  logic               skip;

  // Latched per transaction
  logic [3:0]         digit;
  status_t            err;

  // Dispatch decode
  upc_t               entry;
  status_t            entry_err;

  // Stack RAM
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [DW-1:0]      ram_rdata;

  // Multiply / divide working registers
  logic [CW-1:0]      cnt;
  logic [DW-1:0]      mul_a;
  logic [DW-1:0]      mul_b;
  logic [DW-1:0]      acc;
  logic [DW+MC-1:0]   mul_prod;
  logic [DW-1:0]      quo;
  logic [DW-1:0]      rem;
  logic [DW-1:0]      dsr;
  logic               neg;
  logic [DW:0]        div_trial;

  // Output register
  logic [VALUE_W-1:0] value_q;
  status_t            status_q;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  assign char_ready = !busy;
  assign value      = value_q;
  assign status     = status_q;

  // Microcode fetch; an emitting step stalls while the result register is occupied
  assign ctrl     = urom(upc);
  assign out_free = !result_valid || result_ready;
  assign exec     = busy && !(ctrl.emit && !out_free);

  // RAM holds entries below the top: next-to-top is at depth-2, push spills tos at depth-1
  assign ram_raddr = AW'(depth - DEPTH_W'(2));
  assign ram_waddr = AW'(depth - DEPTH_W'(1));
  assign ram_we    = exec && (ctrl.act == A_PUSH) && (depth != '0);

  assign mul_prod  = mul_a * mul_b[MC-1:0];
  assign div_trial = {rem, quo[DW-1]} - {1'b0, dsr};

  // Character dispatch: picks the microroutine, with all error checks resolved here
  always_comb begin
    entry     = UA_NOP;
    entry_err = ST_OK;
    if (char_in == CH_NUL || char_in == CH_LF) begin
      entry = skip ? UA_ENDSKIP : UA_END;
    end else if (skip) begin
      entry = UA_NOP;
    end else begin
      case (char_in) inside
        CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: begin
          entry = UA_NOP;
        end
        [CH_ZERO:CH_NINE]: begin
          if (depth >= DEPTH_W'(STACK_DEPTH)) begin
            entry     = UA_FAIL;
            entry_err = ST_OVERFLOW;
          end else begin
            entry = UA_PUSH;
          end
        end
        CH_EQ: begin
          if (depth == '0) begin
            entry     = UA_FAIL;
            entry_err = ST_UNDERFLOW;
          end else begin
            entry = UA_POP;
          end
        end
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
          if (depth < DEPTH_W'(2)) begin
            entry     = UA_FAIL;
            entry_err = ST_UNDERFLOW;
          end else begin
            case (char_in)
              CH_PLUS:  entry = UA_ADD;
              CH_MINUS: entry = UA_SUB;
              CH_STAR:  entry = UA_MUL;
              default: begin
                // right operand is tos
                if (tos == '0) begin
                  entry     = UA_FAIL;
                  entry_err = ST_DIVZERO;
                end else begin
                  entry = UA_DIV;
                end
              end
            endcase
          end
        end
        default: begin
          entry     = UA_FAIL;
          entry_err = ST_BADCHAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      upc          <= UA_NOP;
      depth        <= '0;
      running      <= '0;
      skip         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // drained this cycle and not refilled by an emitting step
      if (result_valid && result_ready && !(exec && ctrl.emit)) begin
        result_valid <= 1'b0;
      end

      if (char_valid && char_ready) begin
        busy  <= 1'b1;
        upc   <= entry;
        err   <= entry_err;
        digit <= char_in[3:0];
      end

      if (exec) begin
        case (ctrl.act)
          A_NOP: begin
          end
          A_END: begin
            value_q      <= VALUE_W'(running);
            status_q     <= ST_OK;
            result_valid <= 1'b1;
            depth        <= '0;
            running      <= '0;
          end
          A_ENDSKIP: begin
            skip    <= 1'b0;
            depth   <= '0;
            running <= '0;
          end
          A_FAIL: begin
            value_q      <= '0;
            status_q     <= err;
            result_valid <= 1'b1;
            depth        <= '0;
            running      <= '0;
            skip         <= 1'b1;
          end
          A_PUSH: begin
            tos   <= DW'(digit);
            depth <= depth + DEPTH_W'(1);
          end
          A_POP: begin
            running <= tos;
            tos     <= ram_rdata;
            depth   <= depth - DEPTH_W'(1);
          end
          A_ADD: begin
            tos     <= ram_rdata + tos;
            running <= ram_rdata + tos;
            depth   <= depth - DEPTH_W'(1);
          end
          A_SUB: begin
            tos     <= ram_rdata - tos;
            running <= ram_rdata - tos;
            depth   <= depth - DEPTH_W'(1);
          end
          A_MULINIT: begin
            mul_a <= ram_rdata;
            mul_b <= tos;
            acc   <= '0;
            cnt   <= CW'(MUL_STEPS);
          end
          A_MULSTEP: begin
            acc   <= acc + mul_prod[DW-1:0];
            mul_a <= mul_a << MC;
            mul_b <= mul_b >> MC;
            cnt   <= cnt - CW'(1);
          end
          A_MULFIN: begin
            tos     <= acc;
            running <= acc;
            depth   <= depth - DEPTH_W'(1);
          end
          A_DIVINIT: begin
            quo <= mag(ram_rdata);
            dsr <= mag(tos);
            rem <= '0;
            neg <= ram_rdata[DW-1] ^ tos[DW-1];
            cnt <= CW'(DW);
          end
          A_DIVSTEP: begin
            // restoring division, one quotient bit per step
            if (!div_trial[DW]) begin
              rem <= div_trial[DW-1:0];
              quo <= {quo[DW-2:0], 1'b1};
            end else begin
              rem <= {rem[DW-2:0], quo[DW-1]};
              quo <= {quo[DW-2:0], 1'b0};
            end
            cnt <= cnt - CW'(1);
          end
          A_DIVFIN: begin
            tos     <= neg ? (~quo + 1'b1) : quo;
            running <= neg ? (~quo + 1'b1) : quo;
            depth   <= depth - DEPTH_W'(1);
          end
          default: begin
          end
        endcase

        if (ctrl.last) begin
          busy <= 1'b0;
        end else if (ctrl.loop && cnt != CW'(1)) begin
          upc <= ctrl.target;
        end else begin
          upc <= upc + upc_t'(1);
        end
      end
    end
  end

  rpn_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tos),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    exec && ctrl.emit |-> !result_valid || result_ready)
    else $error("result register overwritten before transaction completed");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    exec && ctrl.act == A_DIVINIT |-> tos != '0)
    else $error("divider started with zero divisor");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    exec && (ctrl.act == A_END || ctrl.act == A_FAIL || ctrl.act == A_ENDSKIP)
    |=> depth == '0 && running == '0)
    else $error("stack not emptied after end or error");

endmodule
